// ===== sv/art_pkg.sv =====
// art_pkg: shared types and constants for the address region table
// no dependencies; imported by every module of the block
`default_nettype none

package art_pkg;

    localparam int TYPE_W  = 3;
    localparam int ADDR_W  = 64;
    localparam int LIMIT_W = 32;

    typedef logic [TYPE_W-1:0]  rtype_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [LIMIT_W-1:0] limit_t;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        KIND_DECLARE  = 2'd0,
        KIND_LOOKUP   = 2'd1,
        KIND_ADD_SIZE = 2'd2,
        KIND_RESIZE   = 2'd3
    } kind_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_STACK_CODE  = 2'd0,
        CFG_HEAP_CODE   = 2'd1,
        CFG_HEAP_LIMIT  = 2'd2,
        CFG_STACK_LIMIT = 2'd3
    } cfg_idx_t;

    localparam rtype_t STACK_CODE_RST  = 3'd1;
    localparam rtype_t HEAP_CODE_RST   = 3'd2;
    localparam limit_t HEAP_LIMIT_RST  = 32'd131072;
    localparam limit_t STACK_LIMIT_RST = 32'd8388608;

    // shared adder operations
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // field write enables of the region memory
    typedef struct packed {
        logic type_en;
        logic start_en;
        logic size_en;
    } mem_wr_t;

endpackage

`default_nettype wire

// ===== sv/address_region_table.sv =====
// address_region_table: sequencer, configuration registers and result strobe
// depends on art_pkg, art_alu, art_region_mem
//
//  channel   signals                                      handshake
//  -------   -------------------------------------------  -------------------------
//  command   start, kind, region_type, address, length    start & !busy
//  result    done, found_type, success                    done, one cycle, no stall
//  config    cfg_valid, cfg_index, cfg_data               cfg_valid & cfg_ready
//
// declare writes its entry in state S_DECL; the other kinds scan entries in
// order through one memory read port and one shared adder: S_READ and S_TYPE per entry
// for a type search, S_READ, S_LO, S_END and S_HI per entry for a lookup, then the bound
// check and update states. done is raised in the cycle after the last step and a new
// command may start in that cycle.
// reset clears the entry count and loads the configuration defaults; entries are
// only read below the count, so the memory needs no clearing pass.
// cfg_ready is always high; the result side cannot stall.
`default_nettype none

module address_region_table #(
    parameter int MAX_REGIONS = 8,
    parameter int PAGE_BITS   = 12
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [1:0]      kind,
    input  wire art_pkg::rtype_t region_type,
    input  wire art_pkg::addr_t  address,
    input  wire art_pkg::addr_t  length,
    output logic                 done,
    output art_pkg::rtype_t      found_type,
    output logic                 success,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_index,
    input  wire art_pkg::limit_t cfg_data
);
    import art_pkg::*;

    localparam int    IDX_W     = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int    CNT_W     = $clog2(MAX_REGIONS + 1);
    localparam addr_t PAGE_MASK = (64'd1 << PAGE_BITS) - 64'd1;

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_DECL      = 15'b000000000000010,
        S_READ      = 15'b000000000000100,
        S_TYPE      = 15'b000000000001000,
        S_LO        = 15'b000000000010000,
        S_END       = 15'b000000000100000,
        S_HI        = 15'b000000001000000,
        S_ADD_SIZE  = 15'b000000010000000,
        S_ADD_START = 15'b000000100000000,
        S_HEAP_NEED = 15'b000001000000000,
        S_HEAP_SET  = 15'b000010000000000,
        S_STK_DIST  = 15'b000100000000000,
        S_STK_ALIGN = 15'b001000000000000,
        S_STK_START = 15'b010000000000000,
        S_STK_SIZE  = 15'b100000000000000
    } state_t;

    state_t           state_reg, state_next;
    kind_t            kind_reg;
    rtype_t           type_reg;
    addr_t            addr_reg;
    addr_t            len_reg;
    addr_t            acc_reg, acc_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic             done_reg, done_next;
    rtype_t           found_reg, found_next;
    logic             ok_reg, ok_next;

    rtype_t           stack_code_reg;
    rtype_t           heap_code_reg;
    limit_t           heap_limit_reg;
    limit_t           stack_limit_reg;

    alu_op_t          alu_op;
    addr_t            alu_a, alu_b, alu_sum;
    logic             alu_carry;

    mem_wr_t          wr;
    logic [IDX_W-1:0] wr_idx;
    rtype_t           wr_type;
    addr_t            wr_start, wr_size;
    logic             rd_en;
    rtype_t           rd_type;
    addr_t            rd_start, rd_size;

    logic             is_heap, is_stack;

    art_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    art_region_mem #(
        .DEPTH (MAX_REGIONS)
    ) u_mem (
        .clk      (clk),
        .wr       (wr),
        .wr_idx   (wr_idx),
        .wr_type  (wr_type),
        .wr_start (wr_start),
        .wr_size  (wr_size),
        .rd_en    (rd_en),
        .rd_idx   (idx_reg[IDX_W-1:0]),
        .rd_type  (rd_type),
        .rd_start (rd_start),
        .rd_size  (rd_size)
    );

    // heap test takes priority over stack
    assign is_heap  = (type_reg == heap_code_reg);
    assign is_stack = (type_reg == stack_code_reg);

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign found_type = found_reg;
    assign success    = ok_reg;
    assign cfg_ready  = 1'b1;
    assign wr_idx     = (state_reg == S_DECL) ? used_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        used_next  = used_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        ok_next    = ok_reg;
        alu_op     = ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;
        wr         = '0;
        wr_type    = type_reg;
        wr_start   = alu_sum;
        wr_size    = alu_sum;
        rd_en      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    state_next = (kind_t'(kind) == KIND_DECLARE) ? S_DECL : S_READ;
                end
            end

            S_DECL:
            begin
                alu_op = ALU_SUB;
                alu_a  = addr_reg;
                alu_b  = len_reg;
                state_next = S_IDLE;
                done_next  = 1'b1;
                found_next = '0;
                if (used_reg == CNT_W'(MAX_REGIONS))
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    wr         = '{type_en: 1'b1, start_en: 1'b1, size_en: 1'b1};
                    wr_start   = is_stack ? alu_sum : addr_reg;
                    wr_size    = len_reg;
                    used_next  = used_reg + CNT_W'(1);
                    ok_next    = 1'b1;
                end
            end

            S_READ:
            begin
                if (idx_reg == used_reg)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    found_next = '0;
                    ok_next    = 1'b0;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = (kind_reg == KIND_LOOKUP) ? S_LO : S_TYPE;
                end
            end

            S_TYPE:
            begin
                if (rd_type == type_reg)
                begin
                    state_next = (kind_reg == KIND_ADD_SIZE) ? S_ADD_SIZE : S_LO;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_READ;
                end
            end

            // lower bound, then end address, then upper bound
            S_LO, S_HI:
            begin
                alu_op = ALU_SUB;
                alu_a  = (state_reg == S_LO) ? addr_reg : acc_reg;
                alu_b  = (state_reg == S_LO) ? rd_start : addr_reg;
                if (alu_carry && state_reg == S_LO)
                begin
                    state_next = S_END;
                end
                else if (alu_carry)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    found_next = (kind_reg == KIND_LOOKUP) ? rd_type : '0;
                    ok_next    = 1'b1;
                end
                else if (kind_reg == KIND_LOOKUP)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_READ;
                end
                else if (is_heap)
                begin
                    state_next = S_HEAP_NEED;
                end
                else if (is_stack)
                begin
                    state_next = S_STK_DIST;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    found_next = '0;
                    ok_next    = 1'b0;
                end
            end

            S_END:
            begin
                alu_a      = rd_start;
                alu_b      = rd_size;
                acc_next   = alu_sum;
                state_next = S_HI;
            end

            S_ADD_SIZE:
            begin
                alu_a   = rd_size;
                alu_b   = len_reg;
                wr      = '{type_en: 1'b0, start_en: 1'b0, size_en: 1'b1};
                if (is_stack)
                begin
                    state_next = S_ADD_START;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    found_next = '0;
                    ok_next    = 1'b1;
                end
            end

            S_ADD_START:
            begin
                alu_op     = ALU_SUB;
                alu_a      = rd_start;
                alu_b      = len_reg;
                wr         = '{type_en: 1'b0, start_en: 1'b1, size_en: 1'b0};
                state_next = S_IDLE;
                done_next  = 1'b1;
                found_next = '0;
                ok_next    = 1'b1;
            end

            S_HEAP_NEED:
            begin
                alu_op     = ALU_SUB;
                alu_a      = addr_reg;
                alu_b      = rd_start;
                acc_next   = alu_sum;
                state_next = S_HEAP_SET;
            end

            // limit check on the raw need, new size is the page-aligned need
            S_HEAP_SET:
            begin
                alu_a      = acc_reg;
                alu_b      = PAGE_MASK;
                state_next = S_IDLE;
                done_next  = 1'b1;
                found_next = '0;
                if (acc_reg[ADDR_W-1:LIMIT_W] != '0 || acc_reg[LIMIT_W-1:0] > heap_limit_reg)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    wr      = '{type_en: 1'b0, start_en: 1'b0, size_en: 1'b1};
                    wr_size = alu_sum & ~PAGE_MASK;
                    ok_next = 1'b1;
                end
            end

            S_STK_DIST:
            begin
                alu_op     = ALU_SUB;
                alu_a      = rd_start;
                alu_b      = addr_reg;
                acc_next   = alu_sum;
                state_next = S_STK_ALIGN;
            end

            S_STK_ALIGN:
            begin
                alu_a      = acc_reg;
                alu_b      = PAGE_MASK;
                acc_next   = alu_sum & ~PAGE_MASK;
                state_next = S_STK_START;
            end

            S_STK_START:
            begin
                alu_op = ALU_SUB;
                alu_a  = rd_start;
                alu_b  = acc_reg;
                if (acc_reg[ADDR_W-1:LIMIT_W] != '0 || acc_reg[LIMIT_W-1:0] > stack_limit_reg)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    found_next = '0;
                    ok_next    = 1'b0;
                end
                else
                begin
                    wr         = '{type_en: 1'b0, start_en: 1'b1, size_en: 1'b0};
                    state_next = S_STK_SIZE;
                end
            end

            S_STK_SIZE:
            begin
                alu_a      = rd_size;
                alu_b      = acc_reg;
                wr         = '{type_en: 1'b0, start_en: 1'b0, size_en: 1'b1};
                state_next = S_IDLE;
                done_next  = 1'b1;
                found_next = '0;
                ok_next    = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    // command capture and working registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg <= kind_t'(kind);
            type_reg <= region_type;
            addr_reg <= address;
            len_reg  <= length;
        end
        acc_reg   <= acc_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        ok_reg    <= ok_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_code_reg  <= STACK_CODE_RST;
            heap_code_reg   <= HEAP_CODE_RST;
            heap_limit_reg  <= HEAP_LIMIT_RST;
            stack_limit_reg <= STACK_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_STACK_CODE:  stack_code_reg  <= cfg_data[TYPE_W-1:0];
                CFG_HEAP_CODE:   heap_code_reg   <= cfg_data[TYPE_W-1:0];
                CFG_HEAP_LIMIT:  heap_limit_reg  <= cfg_data;
                CFG_STACK_LIMIT: stack_limit_reg <= cfg_data;
                default:         stack_code_reg  <= stack_code_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/art_alu.sv =====
// art_alu: the shared 64-bit add / subtract unit of the sequencer
// depends on art_pkg
`default_nettype none

module art_alu (
    input  wire art_pkg::alu_op_t op,
    input  wire art_pkg::addr_t   a,
    input  wire art_pkg::addr_t   b,
    output art_pkg::addr_t        sum,
    output logic                  carry
);
    import art_pkg::*;

    logic [ADDR_W:0] full;
    addr_t           b_eff;

    // subtract is a plus inverted b plus one; carry out means a >= b
    assign b_eff = (op == ALU_SUB) ? ~b : b;
    assign full  = {1'b0, a} + {1'b0, b_eff} + {{ADDR_W{1'b0}}, (op == ALU_SUB)};
    assign sum   = full[ADDR_W-1:0];
    assign carry = full[ADDR_W];

endmodule

`default_nettype wire

// ===== sv/art_region_mem.sv =====
// art_region_mem: region storage (type, start, size), one write and one read port
// depends on art_pkg; read data is registered
`default_nettype none

module art_region_mem #(
    parameter int DEPTH = 8,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire art_pkg::mem_wr_t wr,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire art_pkg::rtype_t  wr_type,
    input  wire art_pkg::addr_t   wr_start,
    input  wire art_pkg::addr_t   wr_size,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_idx,
    output art_pkg::rtype_t       rd_type,
    output art_pkg::addr_t        rd_start,
    output art_pkg::addr_t        rd_size
);
    import art_pkg::*;

    rtype_t type_mem  [DEPTH];
    addr_t  start_mem [DEPTH];
    addr_t  size_mem  [DEPTH];

    // write port, per-field enables
    always_ff @(posedge clk)
    begin
        if (wr.type_en)
        begin
            type_mem[wr_idx] <= wr_type;
        end
        if (wr.start_en)
        begin
            start_mem[wr_idx] <= wr_start;
        end
        if (wr.size_en)
        begin
            size_mem[wr_idx] <= wr_size;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_type  <= type_mem[rd_idx];
            rd_start <= start_mem[rd_idx];
            rd_size  <= size_mem[rd_idx];
        end
    end

endmodule

`default_nettype wire

// ===== dv/region_table_checker.sv =====
`timescale 1ns / 100ps
// region_table_checker: predicts and checks every result of address_region_table
// depends on art_pkg; watches the command, result and configuration channels

module region_table_checker #(
    parameter int MAX_REGIONS = 8,
    parameter int PAGE_BITS   = 12
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic [1:0] kind,
    input  art_pkg::rtype_t region_type,
    input  art_pkg::addr_t  address,
    input  art_pkg::addr_t  length,
    input  wire logic       done,
    input  art_pkg::rtype_t found_type,
    input  wire logic       success,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  art_pkg::limit_t cfg_data,
    output int              error_count,
    output int              pending_results
);
    import art_pkg::*;

    localparam int    REPORT_LIMIT = 10;
    localparam addr_t PAGE_MASK    = (addr_t'(1) << PAGE_BITS) - addr_t'(1);

    typedef struct packed {
        rtype_t found_type;
        logic   success;
    } region_outcome_t;

    // shadow of the region table and its registers
    rtype_t ent_type  [MAX_REGIONS];
    addr_t  ent_start [MAX_REGIONS];
    addr_t  ent_size  [MAX_REGIONS];
    int     used_entries;
    rtype_t stack_code;
    rtype_t heap_code;
    limit_t heap_limit;
    limit_t stack_limit;

    region_outcome_t expected_outcomes[$];
    region_outcome_t want;

    function automatic addr_t page_round_up(addr_t x);
        return (x + PAGE_MASK) & ~PAGE_MASK;
    endfunction

    // upper bound is inclusive, end address wraps at 64 bits
    function automatic logic region_holds(int i, addr_t a);
        addr_t last;
        last = ent_start[i] + ent_size[i];
        return (ent_start[i] <= a) && (a <= last);
    endfunction

    function automatic int first_entry_of(rtype_t rt);
        for (int i = 0; i < used_entries; i++) begin
            if (ent_type[i] == rt)
                return i;
        end
        return -1;
    endfunction

    // applies one command to the shadow table and returns its outcome
    function automatic region_outcome_t apply_region_op(kind_t op, rtype_t rt, addr_t addr,
                                                       addr_t len);
        region_outcome_t res;
        int              slot;
        addr_t           span;
        res  = '0;
        slot = first_entry_of(rt);
        case (op)
            KIND_DECLARE: begin
                if (used_entries < MAX_REGIONS) begin
                    ent_type[used_entries]  = rt;
                    ent_size[used_entries]  = len;
                    ent_start[used_entries] = (rt == stack_code) ? addr - len : addr;
                    used_entries++;
                    res.success = 1'b1;
                end
            end
            KIND_LOOKUP: begin
                for (int i = 0; i < used_entries; i++) begin
                    if (!res.success && region_holds(i, addr)) begin
                        res.found_type = ent_type[i];
                        res.success    = 1'b1;
                    end
                end
            end
            KIND_ADD_SIZE: begin
                if (slot >= 0) begin
                    if (rt == stack_code)
                        ent_start[slot] = ent_start[slot] - len;
                    ent_size[slot] = ent_size[slot] + len;
                    res.success    = 1'b1;
                end
            end
            default: begin
                // resize: heap check wins when both codes are equal
                if (slot >= 0) begin
                    if (region_holds(slot, addr)) begin
                        res.success = 1'b1;
                    end
                    else if (rt == heap_code) begin
                        span = addr - ent_start[slot];
                        if (span <= addr_t'(heap_limit)) begin
                            ent_size[slot] = page_round_up(span);
                            res.success    = 1'b1;
                        end
                    end
                    else if (rt == stack_code) begin
                        span = page_round_up(ent_start[slot] - addr);
                        if (span <= addr_t'(stack_limit)) begin
                            ent_start[slot] = ent_start[slot] - span;
                            ent_size[slot]  = ent_size[slot] + span;
                            res.success     = 1'b1;
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_REGIONS; i++) begin
                ent_type[i]  = '0;
                ent_start[i] = '0;
                ent_size[i]  = '0;
            end
            used_entries = 0;
            stack_code   = STACK_CODE_RST;
            heap_code    = HEAP_CODE_RST;
            heap_limit   = HEAP_LIMIT_RST;
            stack_limit  = STACK_LIMIT_RST;
            expected_outcomes.delete();
            error_count     = 0;
            pending_results = 0;
        end
        else begin
            // result transaction against the oldest prediction
            if (done) begin
                if (expected_outcomes.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: result with no command outstanding: found_type %0d success %0d",
                                 $time, found_type, success);
                end
                else begin
                    want = expected_outcomes.pop_front();
                    if (found_type !== want.found_type || success !== want.success) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: result mismatch: found_type exp %0d got %0d, success exp %0d got %0d",
                                     $time, want.found_type, found_type, want.success, success);
                    end
                end
            end
            // register write transaction
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_STACK_CODE:  stack_code  = cfg_data[TYPE_W-1:0];
                    CFG_HEAP_CODE:   heap_code   = cfg_data[TYPE_W-1:0];
                    CFG_HEAP_LIMIT:  heap_limit  = cfg_data;
                    CFG_STACK_LIMIT: stack_limit = cfg_data;
                endcase
            end
            // command transaction
            if (start && !busy)
                expected_outcomes.push_back(apply_region_op(kind_t'(kind), region_type, address,
                                                            length));
            pending_results = expected_outcomes.size();
        end
    end

endmodule

// ===== dv/tb_address_region_table.sv =====
`timescale 1ns / 100ps
// tb_address_region_table: stimulus and verdict for address_region_table
// depends on art_pkg, the block RTL and region_table_checker

module tb_address_region_table;
    import art_pkg::*;

    localparam int    MAX_REGIONS    = 8;
    localparam int    PAGE_BITS      = 12;
    localparam int    RESET_CYCLES   = 6;
    localparam int    PHASES         = 6;
    localparam int    PHASE_ITEMS    = 125;
    localparam int    DRAIN_CYCLES   = 40;
    localparam int    WATCHDOG_LIMIT = 2000;
    localparam addr_t PAGE           = addr_t'(1) << PAGE_BITS;
    localparam addr_t HEAP_BASE      = 64'h0000_0000_1000_0000;
    localparam addr_t STACK_TOP      = 64'h0000_7fff_0000_0000;
    localparam addr_t HIGH_BASE      = 64'hffff_ffff_ffff_f000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] kind;
    rtype_t     region_type;
    addr_t      address;
    addr_t      length;
    logic       done;
    rtype_t     found_type;
    logic       success;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    limit_t     cfg_data;

    int     error_count;
    int     pending_results;
    int     cmd_accepts = 0;
    int     cfg_accepts = 0;
    int     idle_cycles = 0;
    logic   pauses_on;
    rtype_t stack_now;
    rtype_t heap_now;
    addr_t  bases[$];

    address_region_table #(
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_BITS   (PAGE_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .region_type (region_type),
        .address     (address),
        .length      (length),
        .done        (done),
        .found_type  (found_type),
        .success     (success),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    region_table_checker #(
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_BITS   (PAGE_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .region_type     (region_type),
        .address         (address),
        .length          (length),
        .done            (done),
        .found_type      (found_type),
        .success         (success),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // transaction counters and progress watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (start && !busy)
            cmd_accepts <= cmd_accepts + 1;
        if (cfg_valid && cfg_ready)
            cfg_accepts <= cfg_accepts + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("** address_region_table: FAILED **");
        $finish;
    end

    function automatic int pause_length();
        if (!pauses_on || $urandom_range(0, 99) >= 35)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(7, 40);
        return $urandom_range(1, 6);
    endfunction

    // probe address near a declared region edge, or anywhere
    function automatic addr_t near_address();
        int unsigned sel;
        longint      pages;
        addr_t       a;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return {$urandom, $urandom};
        if (sel < 10)
            return '1;
        if (sel < 11)
            return '0;
        if (sel < 30)
            pages = longint'($urandom_range(0, 8192)) - 4096;
        else
            pages = longint'($urandom_range(0, 128)) - 64;
        a = bases[$urandom_range(0, bases.size() - 1)] + (addr_t'(pages) << PAGE_BITS);
        case ($urandom_range(0, 3))
            0: a = a - 1;
            1: a = a + 1;
            2: a = a + $urandom_range(0, 4095);
            default: ;
        endcase
        return a;
    endfunction

    task automatic send_command(kind_t op, rtype_t rt, addr_t a, addr_t len);
        int seen;
        int gap;
        gap = pause_length();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        kind        <= op;
        region_type <= rt;
        address     <= a;
        length      <= len;
        seen = cmd_accepts;
        do @(negedge clk); while (cmd_accepts == seen);
    endtask

    task automatic write_register(cfg_idx_t idx, limit_t data);
        int seen;
        int gap;
        gap = pause_length();
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        seen = cfg_accepts;
        do @(negedge clk); while (cfg_accepts == seen);
    endtask

    task automatic wait_until_idle();
        do @(negedge clk); while (pending_results != 0 || busy);
    endtask

    initial
    begin
        kind_t       op;
        rtype_t      rt;
        addr_t       a;
        addr_t       len;
        int unsigned sel;
        rtype_t      sc;
        rtype_t      hc;
        limit_t      hl;
        limit_t      sl;

        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = KIND_DECLARE;
        region_type = '0;
        address     = '0;
        length      = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_STACK_CODE;
        cfg_data    = '0;
        stack_now   = STACK_CODE_RST;
        heap_now    = HEAP_CODE_RST;
        pauses_on   = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table: nothing found, nothing to grow
        send_command(KIND_LOOKUP, 3'd0, '0, '0);
        send_command(KIND_ADD_SIZE, HEAP_CODE_RST, '0, PAGE);
        send_command(KIND_RESIZE, HEAP_CODE_RST, HEAP_BASE, '0);

        // heap, stack given by its top, a type-0 region at the top of memory, empty region
        send_command(KIND_DECLARE, HEAP_CODE_RST, HEAP_BASE, PAGE);
        send_command(KIND_DECLARE, STACK_CODE_RST, STACK_TOP, 2 * PAGE);
        send_command(KIND_DECLARE, 3'd0, HIGH_BASE, PAGE - 1);
        send_command(KIND_DECLARE, 3'd7, '0, '0);
        bases.push_back(HEAP_BASE);
        bases.push_back(STACK_TOP);
        bases.push_back(STACK_TOP - 3 * PAGE);
        bases.push_back(HIGH_BASE);
        bases.push_back('0);

        // region bounds, inclusive end, type-0 hit, zero-size region
        send_command(KIND_LOOKUP, 3'd0, HEAP_BASE, '0);
        send_command(KIND_LOOKUP, 3'd0, HEAP_BASE + PAGE, '0);
        send_command(KIND_LOOKUP, 3'd0, HEAP_BASE + PAGE + 1, '0);
        send_command(KIND_LOOKUP, 3'd0, '1, '0);
        send_command(KIND_LOOKUP, 3'd0, '0, '0);

        // growth by amount; the stack start moves down
        send_command(KIND_ADD_SIZE, STACK_CODE_RST, '0, PAGE);
        send_command(KIND_ADD_SIZE, HEAP_CODE_RST, '0, PAGE / 2);

        // resize: already held, heap grow, heap over limit, stack grow, stack over limit
        send_command(KIND_RESIZE, HEAP_CODE_RST, HEAP_BASE + 16, '0);
        send_command(KIND_RESIZE, HEAP_CODE_RST, HEAP_BASE + 64'h5123, '0);
        send_command(KIND_RESIZE, HEAP_CODE_RST, HEAP_BASE + 64'h2_0001, '0);
        send_command(KIND_RESIZE, STACK_CODE_RST, STACK_TOP - 3 * PAGE - 64'h1234, '0);
        send_command(KIND_RESIZE, STACK_CODE_RST, STACK_TOP - 64'h1_0000_0000, '0);

        // resize of a type that is neither heap nor stack, all-ones growth wraps
        send_command(KIND_RESIZE, 3'd7, 64'h10, '0);
        send_command(KIND_ADD_SIZE, 3'd0, '0, '1);

        // fill the table with random regions, then one more into a full table
        for (int t = 3; t <= 6; t++)
        begin
            a   = {$urandom, $urandom} & ~(PAGE - 1);
            len = addr_t'($urandom_range(1, 64)) << PAGE_BITS;
            bases.push_back(a);
            send_command(KIND_DECLARE, rtype_t'(t), a, len);
        end
        send_command(KIND_DECLARE, 3'd5, STACK_TOP, PAGE);

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            start <= 1'b0;
            wait_until_idle();
            case (ph)
                0:
                begin
                    sc = 3'd1; hc = 3'd2; hl = '0; sl = '0;
                end
                1:
                begin
                    sc = 3'd7; hc = 3'd1; hl = '1; sl = '1;
                end
                2:
                begin
                    sc = 3'd3; hc = 3'd3; hl = HEAP_LIMIT_RST; sl = STACK_LIMIT_RST;
                end
                3:
                begin
                    sc = 3'd5; hc = 3'd6; hl = 32'h1000; sl = 32'h3000;
                end
                4:
                begin
                    sc = rtype_t'($urandom_range(1, 7));
                    hc = rtype_t'($urandom_range(1, 7));
                    hl = $urandom >> $urandom_range(0, 31);
                    sl = $urandom >> $urandom_range(0, 31);
                end
                default:
                begin
                    sc = STACK_CODE_RST; hc = HEAP_CODE_RST;
                    hl = HEAP_LIMIT_RST; sl = STACK_LIMIT_RST;
                end
            endcase
            write_register(CFG_STACK_CODE, limit_t'(sc));
            write_register(CFG_HEAP_CODE, limit_t'(hc));
            write_register(CFG_HEAP_LIMIT, hl);
            write_register(CFG_STACK_LIMIT, sl);
            cfg_valid <= 1'b0;
            stack_now = sc;
            heap_now  = hc;
            // one phase runs back to back
            pauses_on = (ph != 2);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 35)
                    op = KIND_LOOKUP;
                else if (sel < 55)
                    op = KIND_ADD_SIZE;
                else if (sel < 92)
                    op = KIND_RESIZE;
                else
                    op = KIND_DECLARE;
                sel = $urandom_range(0, 9);
                if (sel < 3)
                    rt = stack_now;
                else if (sel < 6)
                    rt = heap_now;
                else
                    rt = rtype_t'($urandom_range(0, 7));
                a   = near_address();
                sel = $urandom_range(0, 99);
                if (op == KIND_DECLARE || sel < 2)
                    len = {$urandom, $urandom};
                else if (sel < 10)
                    len = addr_t'($urandom_range(0, 16'hffff));
                else
                    len = addr_t'($urandom_range(0, 16)) << PAGE_BITS;
                send_command(op, rt, a, len);
            end
        end

        start <= 1'b0;
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("** address_region_table: PASSED **");
        else
            $display("** address_region_table: FAILED **");
        $finish;
    end

endmodule
